@@ rtl/rti_pkg.sv @@
// Shared types, widths and codes for the ray/triangle intersection pipeline.
// No dependencies; every other file imports this package.

package rti_pkg;

  // Coordinate width of the ray and of the triangle corners (8 fraction bits).
  localparam int COORD_WIDTH = 24;
  localparam int CW          = COORD_WIDTH;
  // Edge and offset vectors: difference of two coordinates.
  localparam int EW          = CW + 1;
  // One cross-product term and a full cross-product component.
  localparam int MW          = 2 * EW;
  localparam int XW          = MW + 1;
  // Dot products split the wide operand into a low part of EW bits and a high part.
  localparam int HW          = XW - EW;
  localparam int PPW         = EW + HW;
  localparam int TW          = EW + XW;
  localparam int DW          = TW + 2;
  // Sign-corrected values and the u + v sum.
  localparam int FW          = DW + 1;
  localparam int SW          = FW + 1;
  // Determinant threshold.
  localparam int TRW         = 40;
  localparam logic [TRW-1:0] THRESH_RESET = TRW'(1678);

  // Configuration port.
  localparam int REG_COUNT   = 7;
  localparam int IDX_W       = $clog2(REG_COUNT);
  localparam int OFS_W       = 3;
  localparam int ADDR_W      = IDX_W + OFS_W;
  localparam int DATA_W      = 64;

  // Pipeline stages, first to last.
  localparam int ST_EDGE     = 0;
  localparam int ST_XMUL     = 1;
  localparam int ST_XSUB     = 2;
  localparam int ST_DMUL     = 3;
  localparam int ST_DTERM    = 4;
  localparam int ST_DSUM     = 5;
  localparam int ST_FLIP     = 6;
  localparam int ST_OUT      = 7;
  localparam int NSTAGE      = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_DET_THRESH
  } reg_idx_t;

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_PARALLEL = 3'd1,
    OC_U_OUT    = 3'd2,
    OC_V_OUT    = 3'd3,
    OC_BEHIND   = 3'd4
  } outcome_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] y;
    logic signed [EW-1:0] z;
  } evec_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } xvec_t;

endpackage

@@ rtl/rti_edge.sv @@
// First pipeline stage: triangle edges and the origin offset from corner 0.
// Depends on rti_pkg.

module rti_edge import rti_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cvec_t c0,
  input  cvec_t c1,
  input  cvec_t c2,
  input  cvec_t org,
  output evec_t e1,
  output evec_t e2,
  output evec_t t0
);

  evec_t e1_r;
  evec_t e2_r;
  evec_t t0_r;

  // E1 = c1 - c0, E2 = c2 - c0, T = origin - c0 (sign fixed later).
  always_ff @(posedge clk) begin
    if (en) begin
      e1_r.x <= EW'(c1.x) - EW'(c0.x);
      e1_r.y <= EW'(c1.y) - EW'(c0.y);
      e1_r.z <= EW'(c1.z) - EW'(c0.z);
      e2_r.x <= EW'(c2.x) - EW'(c0.x);
      e2_r.y <= EW'(c2.y) - EW'(c0.y);
      e2_r.z <= EW'(c2.z) - EW'(c0.z);
      t0_r.x <= EW'(org.x) - EW'(c0.x);
      t0_r.y <= EW'(org.y) - EW'(c0.y);
      t0_r.z <= EW'(org.z) - EW'(c0.z);
    end
  end

  assign e1 = e1_r;
  assign e2 = e2_r;
  assign t0 = t0_r;

endmodule

@@ rtl/rti_cross.sv @@
// Two pipeline stages forming P = dir x E2 and Q = T x E1.
// Depends on rti_pkg; the edge vectors travel along for the dot products.

module rti_cross import rti_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  evec_t      dir,
  input  evec_t      e1,
  input  evec_t      e2,
  input  evec_t      t0,
  output xvec_t      p,
  output xvec_t      q,
  output evec_t      e1_o,
  output evec_t      e2_o,
  output evec_t      t0_o
);

  logic signed [MW-1:0] pm_r [6];
  logic signed [MW-1:0] qm_r [6];
  evec_t e1_m_r, e2_m_r, t0_m_r;
  evec_t e1_s_r, e2_s_r, t0_s_r;
  xvec_t p_r, q_r;

  // Multiply stage: the six products of each cross product.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pm_r[0] <= MW'(dir.y) * MW'(e2.z);
      pm_r[1] <= MW'(dir.z) * MW'(e2.y);
      pm_r[2] <= MW'(dir.z) * MW'(e2.x);
      pm_r[3] <= MW'(dir.x) * MW'(e2.z);
      pm_r[4] <= MW'(dir.x) * MW'(e2.y);
      pm_r[5] <= MW'(dir.y) * MW'(e2.x);
      qm_r[0] <= MW'(t0.y) * MW'(e1.z);
      qm_r[1] <= MW'(t0.z) * MW'(e1.y);
      qm_r[2] <= MW'(t0.z) * MW'(e1.x);
      qm_r[3] <= MW'(t0.x) * MW'(e1.z);
      qm_r[4] <= MW'(t0.x) * MW'(e1.y);
      qm_r[5] <= MW'(t0.y) * MW'(e1.x);
      e1_m_r  <= e1;
      e2_m_r  <= e2;
      t0_m_r  <= t0;
    end
  end

  // Subtract stage: finish the cross-product components.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r.x  <= XW'(pm_r[0]) - XW'(pm_r[1]);
      p_r.y  <= XW'(pm_r[2]) - XW'(pm_r[3]);
      p_r.z  <= XW'(pm_r[4]) - XW'(pm_r[5]);
      q_r.x  <= XW'(qm_r[0]) - XW'(qm_r[1]);
      q_r.y  <= XW'(qm_r[2]) - XW'(qm_r[3]);
      q_r.z  <= XW'(qm_r[4]) - XW'(qm_r[5]);
      e1_s_r <= e1_m_r;
      e2_s_r <= e2_m_r;
      t0_s_r <= t0_m_r;
    end
  end

  assign p    = p_r;
  assign q    = q_r;
  assign e1_o = e1_s_r;
  assign e2_o = e2_s_r;
  assign t0_o = t0_s_r;

endmodule

@@ rtl/rti_dot.sv @@
// Three-stage dot product of a narrow vector with a wide cross-product vector.
// Depends on rti_pkg; the wide operand is split so each multiplier stays narrow.

module rti_dot import rti_pkg::*; (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  evec_t                a,
  input  xvec_t                b,
  output logic signed [DW-1:0] dot
);

  logic signed [EW-1:0]  av [3];
  logic signed [XW-1:0]  bv [3];
  logic signed [PPW-1:0] pl_r [3];
  logic signed [PPW-1:0] ph_r [3];
  logic signed [TW-1:0]  term_r [3];
  logic signed [DW-1:0]  dot_r;

  // Unpack the vectors into lanes.
  always_comb begin
    av[0] = a.x;
    av[1] = a.y;
    av[2] = a.z;
    bv[0] = b.x;
    bv[1] = b.y;
    bv[2] = b.z;
  end

  // Partial products: the low part is unsigned, the high part carries the sign.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[i] <= PPW'(av[i]) * PPW'($signed({1'b0, bv[i][EW-1:0]}));
        ph_r[i] <= PPW'(av[i]) * PPW'($signed(bv[i][XW-1:EW]));
      end
    end
  end

  // Recombine each lane's partial products into one full-width term.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        term_r[i] <= (TW'(ph_r[i]) <<< EW) + TW'(pl_r[i]);
      end
    end
  end

  // Sum the three lanes.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dot_r <= DW'(term_r[0]) + DW'(term_r[1]) + DW'(term_r[2]);
    end
  end

  assign dot = dot_r;

endmodule

@@ rtl/rti_decide.sv @@
// Last two pipeline stages: sign correction and the ordered hit tests.
// Depends on rti_pkg; the second stage is the output register.

module rti_decide import rti_pkg::*; (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  logic signed [DW-1:0] det,
  input  logic signed [DW-1:0] u,
  input  logic signed [DW-1:0] v,
  input  logic signed [DW-1:0] t,
  input  logic [TRW-1:0]       thr,
  output logic                 hit,
  output outcome_t             outcome
);

  logic                 flip;
  logic signed [FW-1:0] detf_r, uf_r, vf_r, tf_r;
  logic signed [FW-1:0] thr_s;
  logic signed [SW-1:0] uv_sum;
  outcome_t             oc;
  logic                 hit_r;
  outcome_t             outcome_r;

  // A determinant that is not positive flips T, which negates u, v and t with it.
  assign flip = det[DW-1] || (det == '0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      detf_r <= flip ? -FW'(det) : FW'(det);
      uf_r   <= flip ? -FW'(u)   : FW'(u);
      vf_r   <= flip ? -FW'(v)   : FW'(v);
      tf_r   <= flip ? -FW'(t)   : FW'(t);
    end
  end

  // Ordered tests; the first one that fails names the outcome.
  always_comb begin
    thr_s  = FW'(thr);
    uv_sum = SW'(uf_r) + SW'(vf_r);
    if (detf_r < thr_s) begin
      oc = OC_PARALLEL;
    end else if (uf_r[FW-1] || (detf_r < uf_r)) begin
      oc = OC_U_OUT;
    end else if (vf_r[FW-1] || (SW'(detf_r) < uv_sum)) begin
      oc = OC_V_OUT;
    end else if (tf_r[FW-1]) begin
      oc = OC_BEHIND;
    end else begin
      oc = OC_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit_r     <= (oc == OC_HIT);
      outcome_r <= oc;
    end
  end

  assign hit     = hit_r;
  assign outcome = outcome_r;

endmodule

@@ rtl/ray_triangle_intersect_top.sv @@
// Ray/triangle hit test, top level: configuration registers, stage control, datapath.
// Requests pass the edge, cross-product, dot-product, flip and output stages in order.
// Throughput: one triangle per cycle; each stage holds only while the one after it is full.
// Reset (synchronous, rst_n low) empties the pipeline and restores the ray and threshold.
// Depends on rti_pkg, rti_edge, rti_cross, rti_dot and rti_decide.

module ray_triangle_intersect_top import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Triangle requests
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_corner0_x,
  input  logic signed [CW-1:0] in_corner0_y,
  input  logic signed [CW-1:0] in_corner0_z,
  input  logic signed [CW-1:0] in_corner1_x,
  input  logic signed [CW-1:0] in_corner1_y,
  input  logic signed [CW-1:0] in_corner1_z,
  input  logic signed [CW-1:0] in_corner2_x,
  input  logic signed [CW-1:0] in_corner2_y,
  input  logic signed [CW-1:0] in_corner2_z,
  // Results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [2:0]           out_outcome,
  // Configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [CW-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [TRW-1:0]       thr_r;
  reg_idx_t             reg_idx;
  logic                 cfg_wr;

  logic [NSTAGE-1:0]    vld_r, vld_nxt;
  logic [NSTAGE-1:0]    en;
  logic                 in_fire, out_fire;

  cvec_t                c0, c1, c2, org;
  evec_t                dir_e;
  evec_t                e1, e2, t0;
  evec_t                e1_x, e2_x, t0_x;
  xvec_t                p, q;
  logic signed [DW-1:0] det, u_dot, v_dot, t_dot;
  outcome_t             outcome;

  // Configuration port: zero wait states, one register per 8-byte slot.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:OFS_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= '0;
      thr_r   <= THRESH_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X:   org_x_r <= pwdata[CW-1:0];
        REG_ORIGIN_Y:   org_y_r <= pwdata[CW-1:0];
        REG_ORIGIN_Z:   org_z_r <= pwdata[CW-1:0];
        REG_DIR_X:      dir_x_r <= pwdata[CW-1:0];
        REG_DIR_Y:      dir_y_r <= pwdata[CW-1:0];
        REG_DIR_Z:      dir_z_r <= pwdata[CW-1:0];
        REG_DET_THRESH: thr_r   <= pwdata[TRW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:   prdata = DATA_W'(unsigned'(org_x_r));
      REG_ORIGIN_Y:   prdata = DATA_W'(unsigned'(org_y_r));
      REG_ORIGIN_Z:   prdata = DATA_W'(unsigned'(org_z_r));
      REG_DIR_X:      prdata = DATA_W'(unsigned'(dir_x_r));
      REG_DIR_Y:      prdata = DATA_W'(unsigned'(dir_y_r));
      REG_DIR_Z:      prdata = DATA_W'(unsigned'(dir_z_r));
      REG_DET_THRESH: prdata = DATA_W'(thr_r);
      default:        prdata = '0;
    endcase
  end

  // Stage enables: a stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[ST_EDGE];
  assign out_valid = vld_r[ST_OUT];
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Operand bundles.
  assign c0      = '{x: in_corner0_x, y: in_corner0_y, z: in_corner0_z};
  assign c1      = '{x: in_corner1_x, y: in_corner1_y, z: in_corner1_z};
  assign c2      = '{x: in_corner2_x, y: in_corner2_y, z: in_corner2_z};
  assign org     = '{x: org_x_r, y: org_y_r, z: org_z_r};
  assign dir_e.x = EW'(dir_x_r);
  assign dir_e.y = EW'(dir_y_r);
  assign dir_e.z = EW'(dir_z_r);

  // Datapath.
  rti_edge u_edge (
    .clk (clk),
    .en  (en[ST_EDGE]),
    .c0  (c0),
    .c1  (c1),
    .c2  (c2),
    .org (org),
    .e1  (e1),
    .e2  (e2),
    .t0  (t0)
  );

  rti_cross u_cross (
    .clk  (clk),
    .en   (en[ST_XSUB:ST_XMUL]),
    .dir  (dir_e),
    .e1   (e1),
    .e2   (e2),
    .t0   (t0),
    .p    (p),
    .q    (q),
    .e1_o (e1_x),
    .e2_o (e2_x),
    .t0_o (t0_x)
  );

  rti_dot u_dot_det (
    .clk (clk),
    .en  (en[ST_DSUM:ST_DMUL]),
    .a   (e1_x),
    .b   (p),
    .dot (det)
  );

  rti_dot u_dot_u (
    .clk (clk),
    .en  (en[ST_DSUM:ST_DMUL]),
    .a   (t0_x),
    .b   (p),
    .dot (u_dot)
  );

  rti_dot u_dot_v (
    .clk (clk),
    .en  (en[ST_DSUM:ST_DMUL]),
    .a   (dir_e),
    .b   (q),
    .dot (v_dot)
  );

  rti_dot u_dot_t (
    .clk (clk),
    .en  (en[ST_DSUM:ST_DMUL]),
    .a   (e2_x),
    .b   (q),
    .dot (t_dot)
  );

  rti_decide u_decide (
    .clk     (clk),
    .en      (en[ST_OUT:ST_FLIP]),
    .det     (det),
    .u       (u_dot),
    .v       (v_dot),
    .t       (t_dot),
    .thr     (thr_r),
    .hit     (out_hit),
    .outcome (outcome)
  );

  assign out_outcome = outcome;

  // An accepted request with no result leaving adds exactly one item in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_fire) |=> ($countones(vld_r) == $past($countones(vld_r)) + 1))
    else $error("pipeline occupancy did not grow by one on a lone input request");

  // A delivered result with no new request removes exactly one item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && out_fire) |=> ($countones(vld_r) + 1 == $past($countones(vld_r))))
    else $error("pipeline occupancy did not shrink by one on a lone output request");

  // An empty first stage always takes a request, whatever the output side does.
  assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[ST_EDGE] |-> in_ready)
    else $error("input stalled with an empty first stage");

  // The hit flag and the outcome code agree.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_outcome == OC_HIT)))
    else $error("hit flag disagrees with outcome code");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for ray_triangle_intersect_top: triangle requests in, hit verdicts out.
// Expected verdicts come from an exact 128-bit integer predictor kept in this file.
// Depends on rti_pkg and the RTL of ray_triangle_intersect_top.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int PIPE_LATENCY    = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int MAX_WAIT        = 13;
  localparam int SQUEEZE_CYCLES  = 150;
  localparam int SQUEEZE_ITEMS   = 40;
  localparam int ORIGIN_SPAN     = 1 << 18;
  localparam int DIR_SPAN        = 1 << 12;
  localparam int CMAX            = (1 << (CW - 1)) - 1;
  localparam int CMIN            = -(1 << (CW - 1));
  // Index past the last register; writes there must be dropped.
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(REG_COUNT);

  typedef struct packed {
    cvec_t c0;
    cvec_t c1;
    cvec_t c2;
  } facet_t;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    wide_t x;
    wide_t y;
    wide_t z;
  } wvec_t;

  typedef struct {
    logic     hit;
    outcome_t oc;
  } verdict_t;

  typedef enum logic {ROW_CFG, ROW_TRI} row_kind_t;
  typedef struct {
    row_kind_t         kind;
    logic [IDX_W-1:0]  sel;
    logic [DATA_W-1:0] value;
    facet_t            facet;
    logic              known;
    outcome_t          oc;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  facet_t            offer;
  logic              out_valid;
  logic              out_ready;
  logic              out_hit;
  logic [2:0]        out_outcome;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow copy of the ray and threshold registers.
  cvec_t            ray_org;
  cvec_t            ray_dir;
  logic [TRW-1:0]   det_floor;

  verdict_t  pending_verdicts[$];
  plan_row_t plan[$];
  int        tally[5];
  int        errors;
  int        checked;
  int        cycles;
  int        ray_settings;
  bit        squeeze;
  bit        squeeze_done;
  bit        source_fast;
  bit        sink_fast;

  ray_triangle_intersect_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_corner0_x (offer.c0.x),
    .in_corner0_y (offer.c0.y),
    .in_corner0_z (offer.c0.z),
    .in_corner1_x (offer.c1.x),
    .in_corner1_y (offer.c1.y),
    .in_corner1_z (offer.c1.z),
    .in_corner2_x (offer.c2.x),
    .in_corner2_y (offer.c2.y),
    .in_corner2_z (offer.c2.z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_outcome  (out_outcome),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Exact vector arithmetic on sign-extended coordinates.
  function automatic wvec_t lift(cvec_t v);
    wvec_t r;
    r.x = $signed(v.x);
    r.y = $signed(v.y);
    r.z = $signed(v.z);
    return r;
  endfunction

  function automatic wvec_t vsub(wvec_t a, wvec_t b);
    wvec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wvec_t cross3(wvec_t a, wvec_t b);
    wvec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t dot3(wvec_t a, wvec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // Runs the hit test on one triangle against the current ray and returns the first failing check.
  function automatic outcome_t classify_facet(facet_t f);
    wvec_t org, dir, c0, e1, e2, p, tv, q;
    wide_t det, u, v, floor_w;
    org = lift(ray_org);
    dir = lift(ray_dir);
    c0  = lift(f.c0);
    e1  = vsub(lift(f.c1), c0);
    e2  = vsub(lift(f.c2), c0);
    p   = cross3(dir, e2);
    det = dot3(e1, p);
    // A zero or negative determinant takes the flipped branch.
    if (det > 0) begin
      tv = vsub(org, c0);
    end else begin
      tv  = vsub(c0, org);
      det = -det;
    end
    floor_w = '0;
    floor_w[TRW-1:0] = det_floor;
    if (det < floor_w) return OC_PARALLEL;
    u = dot3(tv, p);
    if (u < 0 || u > det) return OC_U_OUT;
    q = cross3(tv, e1);
    v = dot3(dir, q);
    if (v < 0 || u + v > det) return OC_V_OUT;
    if (dot3(e2, q) < 0) return OC_BEHIND;
    return OC_HIT;
  endfunction

  // Only the low bits of a register write count; unknown indexes are dropped.
  function automatic void apply_write(logic [IDX_W-1:0] sel, logic [DATA_W-1:0] value);
    case (sel)
      REG_ORIGIN_X:   ray_org.x = value[CW-1:0];
      REG_ORIGIN_Y:   ray_org.y = value[CW-1:0];
      REG_ORIGIN_Z:   ray_org.z = value[CW-1:0];
      REG_DIR_X:      ray_dir.x = value[CW-1:0];
      REG_DIR_Y:      ray_dir.y = value[CW-1:0];
      REG_DIR_Z:      ray_dir.z = value[CW-1:0];
      REG_DET_THRESH: det_floor = value[TRW-1:0];
      default: ;
    endcase
  endfunction

  function automatic int rnd_s(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic cvec_t pt3(int x, int y, int z);
    cvec_t r;
    r.x = CW'(x);
    r.y = CW'(y);
    r.z = CW'(z);
    return r;
  endfunction

  function automatic facet_t facet3(cvec_t a, cvec_t b, cvec_t c);
    facet_t f;
    f.c0 = a;
    f.c1 = b;
    f.c2 = c;
    return f;
  endfunction

  function automatic plan_row_t tri_row(facet_t f, logic known, outcome_t oc);
    plan_row_t r;
    r.kind  = ROW_TRI;
    r.sel   = '0;
    r.value = '0;
    r.facet = f;
    r.known = known;
    r.oc    = oc;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [IDX_W-1:0] sel, logic [DATA_W-1:0] value);
    plan_row_t r;
    r.kind  = ROW_CFG;
    r.sel   = sel;
    r.value = value;
    r.facet = '0;
    r.known = 1'b0;
    r.oc    = OC_HIT;
    return r;
  endfunction

  // Appends one row at the end of the directed table.
  function automatic void queue_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic int rail_value();
    case ($urandom_range(0, 3))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Random triangle: mostly built around a point on the ray line, the rest noise or degenerate.
  function automatic facet_t random_facet();
    facet_t       f;
    logic [255:0] bits;
    int           pick, k, span, i;
    int           o[3], d[3], pt[3], a[3], b[3], s[3], j[3];
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      bits = {$urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom()};
      f = bits[$bits(facet_t)-1:0];
      if ($urandom_range(0, 3) == 0) begin
        f = facet3(pt3(rail_value(), rail_value(), rail_value()),
                   pt3(rail_value(), rail_value(), rail_value()),
                   pt3(rail_value(), rail_value(), rail_value()));
      end
      return f;
    end
    o[0] = $signed(ray_org.x);
    o[1] = $signed(ray_org.y);
    o[2] = $signed(ray_org.z);
    d[0] = $signed(ray_dir.x);
    d[1] = $signed(ray_dir.y);
    d[2] = $signed(ray_dir.z);
    // Negative steps along the ray put the triangle behind the origin.
    k    = int'($urandom_range(0, 72)) - 8;
    span = 1 << $urandom_range(6, 16);
    for (i = 0; i < 3; i++) begin
      pt[i] = o[i] + k * d[i];
      a[i]  = rnd_s(span);
      b[i]  = rnd_s(span);
      j[i]  = rnd_s(64);
      s[i]  = ($urandom_range(0, 3) == 0) ? rnd_s(span) : 0;
    end
    f = facet3(pt3(pt[0] + a[0] + s[0], pt[1] + a[1] + s[1], pt[2] + a[2] + s[2]),
               pt3(pt[0] + b[0] + s[0], pt[1] + b[1] + s[1], pt[2] + b[2] + s[2]),
               pt3(pt[0] - a[0] - b[0] + j[0] + s[0], pt[1] - a[1] - b[1] + j[1] + s[1],
                   pt[2] - a[2] - b[2] + j[2] + s[2]));
    if ($urandom_range(0, 1) == 1) f = facet3(f.c0, f.c2, f.c1);
    // Degenerate shapes: repeated corner or three points on a line.
    if (pick == 2) begin
      if ($urandom_range(0, 1) == 1) begin
        f.c2 = f.c1;
      end else begin
        f.c2 = pt3(2 * $signed(f.c1.x) - $signed(f.c0.x), 2 * $signed(f.c1.y) - $signed(f.c0.y),
                   2 * $signed(f.c1.z) - $signed(f.c0.z));
      end
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s of result %0d: got %0d, expected %0d",
             $time, what, checked, got, want);
    errors++;
  endtask

  // Waits until every pending verdict has come back and the pipeline has drained.
  task automatic settle_block();
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // One register write: setup phase, then access phase until pready.
  task automatic write_reg(logic [IDX_W-1:0] sel, logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, {OFS_W{1'b0}}};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    apply_write(sel, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // New ray and threshold for a random phase; upper bits of each write carry junk.
  task automatic program_ray(int ph);
    logic [DATA_W-1:0] word[REG_COUNT];
    int                r;
    for (r = 0; r < REG_COUNT; r++) word[r] = {$urandom(), $urandom()};
    if (ph != PHASES - 1) begin
      for (r = 0; r < 3; r++) word[r][CW-1:0] = CW'(rnd_s(ORIGIN_SPAN));
      for (r = 3; r < 6; r++) word[r][CW-1:0] = CW'(rnd_s(DIR_SPAN));
      case (ph % 4)
        0:       word[REG_DET_THRESH][TRW-1:0] = THRESH_RESET;
        1:       word[REG_DET_THRESH][TRW-1:0] = '0;
        2:       word[REG_DET_THRESH][TRW-1:0] = TRW'($urandom_range(0, 1 << 24));
        default: ;
      endcase
    end
    for (r = 0; r < REG_COUNT; r++) write_reg(IDX_W'(r), word[r]);
    ray_settings++;
  endtask

  // Offers one triangle request and records its verdict once accepted.
  task automatic send_facet(facet_t f, logic known, outcome_t oc);
    int       gap;
    outcome_t want;
    verdict_t vd;
    if ($urandom_range(0, 39) == 0) source_fast = !source_fast;
    gap = (source_fast || squeeze) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    offer    = f;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    want   = known ? oc : classify_facet(f);
    vd.hit = (want == OC_HIT);
    vd.oc  = want;
    pending_verdicts.insert(pending_verdicts.size(), vd);
    @(negedge clk);
  endtask

  // Directed requests: reset ray, zero threshold, axis-aligned ray, then extremes.
  task automatic load_plan();
    queue_row(tri_row(facet3(pt3(0, 0, 0), pt3(0, 0, 0), pt3(0, 0, 0)), 1'b1, OC_PARALLEL));
    queue_row(tri_row(facet3(pt3(CMAX, CMAX, CMAX), pt3(CMIN, CMIN, CMIN),
                             pt3(CMAX, CMIN, CMAX)), 1'b1, OC_PARALLEL));
    // Zero threshold with a zero direction: the later checks decide.
    queue_row(cfg_row(REG_DET_THRESH, 64'h0));
    queue_row(tri_row(facet3(pt3(0, 0, 0), pt3(256, 0, 0), pt3(0, 256, 0)), 1'b1, OC_HIT));
    queue_row(tri_row(facet3(pt3(256, 256, 256), pt3(512, 0, 0), pt3(0, 512, -256)),
                      1'b0, OC_HIT));
    queue_row(tri_row(facet3(pt3(256, 256, 256), pt3(0, 512, -256), pt3(512, 0, 0)),
                      1'b0, OC_HIT));
    // Ray from z = -10 along +z, default threshold, junk above the register widths.
    queue_row(cfg_row(REG_ORIGIN_X, 64'hDEAD_BEEF_0000_0000));
    queue_row(cfg_row(REG_ORIGIN_Y, 64'h1234_5678_9A00_0000));
    queue_row(cfg_row(REG_ORIGIN_Z, 64'h0000_0055_00FF_F600));
    queue_row(cfg_row(REG_DIR_X, 64'hFFFF_FFFF_FF00_0000));
    queue_row(cfg_row(REG_DIR_Y, 64'h0F00_0000_0000_0000));
    queue_row(cfg_row(REG_DIR_Z, 64'hFFFF_FFFF_FF00_0100));
    queue_row(cfg_row(REG_DET_THRESH, 64'hFFFF_FF00_0000_068E));
    queue_row(cfg_row(REG_UNUSED, 64'h0000_0000_0000_0100));
    queue_row(tri_row(facet3(pt3(-256, -256, 0), pt3(512, -256, 0), pt3(-256, 512, 0)),
                      1'b1, OC_HIT));
    queue_row(tri_row(facet3(pt3(-256, -256, 0), pt3(-256, 512, 0), pt3(512, -256, 0)),
                      1'b1, OC_HIT));
    queue_row(tri_row(facet3(pt3(-256, -256, -5120), pt3(512, -256, -5120),
                             pt3(-256, 512, -5120)), 1'b1, OC_BEHIND));
    queue_row(tri_row(facet3(pt3(0, 0, 0), pt3(256, 0, 0), pt3(0, 0, 256)),
                      1'b1, OC_PARALLEL));
    queue_row(tri_row(facet3(pt3(100, 200, 0), pt3(300, -50, 0), pt3(300, -50, 0)),
                      1'b1, OC_PARALLEL));
    queue_row(tri_row(facet3(pt3(256, 256, 0), pt3(768, 256, 0), pt3(256, 768, 0)),
                      1'b0, OC_HIT));
    queue_row(tri_row(facet3(pt3(-768, -256, 0), pt3(-256, -256, 0), pt3(-768, 256, 0)),
                      1'b0, OC_HIT));
    // Extreme ray components and the largest threshold.
    queue_row(cfg_row(REG_ORIGIN_X, 64'h0000_0000_007F_FFFF));
    queue_row(cfg_row(REG_ORIGIN_Y, 64'hFFFF_FFFF_FF80_0000));
    queue_row(cfg_row(REG_ORIGIN_Z, 64'h0000_0000_0080_0000));
    queue_row(cfg_row(REG_DIR_X, 64'h0000_0000_0080_0000));
    queue_row(cfg_row(REG_DIR_Y, 64'h0000_0000_007F_FFFF));
    queue_row(cfg_row(REG_DIR_Z, 64'h0000_0000_0080_0000));
    queue_row(cfg_row(REG_DET_THRESH, 64'hFFFF_FFFF_FFFF_FFFF));
    queue_row(tri_row(facet3(pt3(CMAX, CMAX, CMAX), pt3(CMAX, CMAX, CMAX),
                             pt3(CMAX, CMAX, CMAX)), 1'b1, OC_PARALLEL));
    queue_row(tri_row(facet3(pt3(CMIN, CMIN, CMIN), pt3(CMAX, CMIN, CMIN),
                             pt3(CMIN, CMAX, CMAX)), 1'b0, OC_HIT));
    queue_row(tri_row(facet3(pt3(CMAX, CMAX, CMIN), pt3(CMIN, CMAX, CMAX),
                             pt3(CMAX, CMIN, CMAX)), 1'b0, OC_HIT));
    queue_row(cfg_row(REG_DET_THRESH, 64'h0));
    queue_row(tri_row(facet3(pt3(CMAX, CMAX, CMIN), pt3(CMIN, CMAX, CMAX),
                             pt3(CMAX, CMIN, CMAX)), 1'b0, OC_HIT));
    queue_row(tri_row(facet3(pt3(CMIN, CMAX, CMIN), pt3(CMAX, CMIN, CMAX),
                             pt3(0, -1, 1)), 1'b0, OC_HIT));
  endtask

  // Result side: random stalls, idle-free stretches, and one long hold while the input is busy.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (squeeze && !squeeze_done) begin
        out_ready    = 1'b0;
        squeeze_done = 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) sink_fast = !sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Each accepted result is compared with the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("arrival (nothing pending)", int'(out_outcome), -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", int'(out_hit), int'(want.hit));
        if (out_outcome !== want.oc) report_mismatch("outcome", int'(out_outcome), int'(want.oc));
        tally[want.oc]++;
      end
      checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycles, pending_verdicts.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    int ph, n, r;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    offer     = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    ray_org   = '0;
    ray_dir   = '0;
    det_floor = THRESH_RESET;
    load_plan();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (r = 0; r < plan.size(); r++) begin
      if (plan[r].kind == ROW_CFG) begin
        settle_block();
        write_reg(plan[r].sel, plan[r].value);
      end else begin
        send_facet(plan[r].facet, plan[r].known, plan[r].oc);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle_block();
      program_ray(ph);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 60) squeeze = 1'b1;
        if (ph == 2 && n == 60 + SQUEEZE_ITEMS) squeeze = 1'b0;
        send_facet(random_facet(), 1'b0, OC_HIT);
      end
    end

    settle_block();
    $display("Checked %0d triangle results over %0d random ray settings plus the directed table.",
             checked, ray_settings);
    $display("Outcomes seen: %0d hit, %0d near parallel, %0d u outside, %0d v outside, %0d behind.",
             tally[OC_HIT], tally[OC_PARALLEL], tally[OC_U_OUT], tally[OC_V_OUT], tally[OC_BEHIND]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rti_pkg.sv
rtl/rti_edge.sv
rtl/rti_cross.sv
rtl/rti_dot.sv
rtl/rti_decide.sv
rtl/ray_triangle_intersect_top.sv
bench/testbench.sv
